### sv/button_filter_press_repeat_macros.svh
// Assertion macros shared by the button filter checker.
// Depends on nothing; included by the files that assert.
`ifndef BUTTON_FILTER_PRESS_REPEAT_MACROS_SVH
`define BUTTON_FILTER_PRESS_REPEAT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define BFPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define BFPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bfpr_pkg.sv
// Shared types and constants of the button filter with press and auto-repeat.
// No dependencies; imported by every RTL module of the block.
package bfpr_pkg;

  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [LEVEL_W-1:0] WEIGHT_RST    = 16'd6554;
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 16'd32768;
  localparam logic [LEVEL_W-1:0] LONG_RST      = 16'd200;
  localparam logic [LEVEL_W-1:0] PERIOD_RST    = 16'd25;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_WEIGHT    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_LONG      = 2'd2,
    REG_PERIOD    = 2'd3
  } reg_idx_e;

  // Configuration seen by every lane
  typedef struct packed {
    logic [LEVEL_W-1:0] weight;
    logic [LEVEL_W-1:0] threshold;
    logic [LEVEL_W-1:0] long_ticks;
    logic [LEVEL_W-1:0] period;
  } cfg_t;

  // Per-button findings for one tick
  typedef struct packed {
    logic press;
    logic rel;
    logic rpt;
    logic held;
  } lane_flags_t;

endpackage

### sv/bfpr_regs.sv
// APB-style configuration registers of the button filter.
// Depends on bfpr_pkg for the register map and reset values.
module bfpr_regs import bfpr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write the addressed register, keeping the low 16 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight     <= WEIGHT_RST;
      cfg_q.threshold  <= THRESHOLD_RST;
      cfg_q.long_ticks <= LONG_RST;
      cfg_q.period     <= PERIOD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_WEIGHT:    cfg_q.weight     <= pwdata[LEVEL_W-1:0];
        REG_THRESHOLD: cfg_q.threshold  <= pwdata[LEVEL_W-1:0];
        REG_LONG:      cfg_q.long_ticks <= pwdata[LEVEL_W-1:0];
        REG_PERIOD:    cfg_q.period     <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_WEIGHT:    prdata = {{(CFG_DATA_W-LEVEL_W){1'b0}}, cfg_q.weight};
      REG_THRESHOLD: prdata = {{(CFG_DATA_W-LEVEL_W){1'b0}}, cfg_q.threshold};
      REG_LONG:      prdata = {{(CFG_DATA_W-LEVEL_W){1'b0}}, cfg_q.long_ticks};
      REG_PERIOD:    prdata = {{(CFG_DATA_W-LEVEL_W){1'b0}}, cfg_q.period};
      default:       prdata = '0;
    endcase
  end

endmodule

### sv/bfpr_lane.sv
// One button lane: exponential level filter, press decision, hold and repeat counters.
// Depends on bfpr_pkg for cfg_t and lane_flags_t.
module bfpr_lane import bfpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        pin_i,
  input  cfg_t        cfg_i,
  output lane_flags_t flags_o
);

  localparam int unsigned PROD_W = 2*LEVEL_W + 3;

  logic [LEVEL_W-1:0] level_q, level_d;
  logic               pressed_q, pressed_d;
  logic [LEVEL_W-1:0] hold_q, hold_d;
  logic [LEVEL_W-1:0] phase_q, phase_d;

  logic signed [LEVEL_W+1:0]   diff_s;
  logic signed [PROD_W-1:0]    prod_s;
  logic signed [LEVEL_W+1:0]   step_s;
  logic [LEVEL_W-1:0]          hold_inc;
  logic [LEVEL_W:0]            phase_inc;
  logic                        phase_wrap;
  logic                        past_long;

  // Filter: step toward full scale on a low pin, toward zero on a high pin
  always_comb begin
    if (!pin_i) begin
      diff_s = 18'sd65536 - $signed({2'b00, level_q});
    end else begin
      diff_s = -$signed({2'b00, level_q});
    end
    prod_s  = PROD_W'(diff_s) * PROD_W'($signed({1'b0, cfg_i.weight}));
    // arithmetic shift gives floor for negative products
    step_s  = prod_s[2*LEVEL_W+1:LEVEL_W];
    level_d = level_q + step_s[LEVEL_W-1:0];
  end

  // Press decision and counters
  always_comb begin
    pressed_d  = level_d > cfg_i.threshold;
    hold_inc   = (hold_q != '1) ? hold_q + 1'b1 : hold_q;
    hold_d     = pressed_d ? hold_inc : '0;
    past_long  = pressed_d && (hold_d > cfg_i.long_ticks);
    phase_inc  = {1'b0, phase_q} + 1'b1;
    phase_wrap = phase_inc >= {1'b0, cfg_i.period};
    if (!pressed_d) begin
      phase_d = '0;
    end else if (past_long) begin
      phase_d = phase_wrap ? '0 : phase_inc[LEVEL_W-1:0];
    end else begin
      phase_d = phase_q;
    end
  end

  assign flags_o.press = pressed_d && !pressed_q;
  assign flags_o.rel   = !pressed_d && pressed_q;
  assign flags_o.rpt   = past_long && (phase_q == '0);
  assign flags_o.held  = pressed_d;

  // Advance the lane state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      pressed_q <= 1'b0;
      hold_q    <= '0;
      phase_q   <= '0;
    end else if (en_i) begin
      level_q   <= level_d;
      pressed_q <= pressed_d;
      hold_q    <= hold_d;
      phase_q   <= phase_d;
    end
  end

endmodule

### sv/bfpr_merge.sv
// Merge stage: gathers the lane flags into event masks and holds them in a
// result register with a skid entry. Depends on bfpr_pkg for lane_flags_t.
module bfpr_merge import bfpr_pkg::*; #(
  parameter int unsigned BUTTONS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               accept_o,
  input  lane_flags_t        flags_i [BUTTONS],
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BUTTONS-1:0] press_o,
  output logic [BUTTONS-1:0] rel_o,
  output logic [BUTTONS-1:0] rpt_o,
  output logic [BUTTONS-1:0] held_o
);

  localparam int unsigned RES_W = 4 * BUTTONS;

  logic [RES_W-1:0] res_d;
  logic [RES_W-1:0] out_q, skid_q;
  logic             out_valid_q, skid_valid_q;
  logic             out_pop;

  // Combine the lane findings into the four masks
  always_comb begin
    for (int i = 0; i < BUTTONS; i++) begin
      res_d[i]             = flags_i[i].press;
      res_d[BUTTONS+i]     = flags_i[i].rel;
      res_d[2*BUTTONS+i]   = flags_i[i].rpt;
      res_d[3*BUTTONS+i]   = flags_i[i].held;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign accept_o   = in_valid_i && !skid_valid_q;
  assign out_pop    = out_valid_q && !out_stall_i;

  // Track occupancy of the result register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept_o) begin
      if (out_valid_q && !out_pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Move payload: skid drains first, new requests fill whichever entry is free
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (accept_o) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign press_o     = out_q[BUTTONS-1:0];
  assign rel_o       = out_q[2*BUTTONS-1:BUTTONS];
  assign rpt_o       = out_q[3*BUTTONS-1:2*BUTTONS];
  assign held_o      = out_q[4*BUTTONS-1:3*BUTTONS];

endmodule

### sv/button_filter_press_repeat.sv
// Button filter with press/release events and long-press auto-repeat.
// A result is held in the result register, or the skid entry if that stays full.
// Throughput: one request per cycle while in_stall_o is low; lanes step per accept.
// in_stall_o rises only while both the result register and the skid entry are full.
// Reset (rst_ni, async, active low) restores default config and zeroes all lane state.
module button_filter_press_repeat import bfpr_pkg::*; #(
  parameter int unsigned BUTTONS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [BUTTONS-1:0]    pin_levels_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [BUTTONS-1:0]    press_events_o,
  output logic [BUTTONS-1:0]    release_events_o,
  output logic [BUTTONS-1:0]    repeat_events_o,
  output logic [BUTTONS-1:0]    held_mask_o
);

  cfg_t        cfg;
  logic        accept;
  lane_flags_t flags [BUTTONS];

  bfpr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // One filter lane per button
  for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
    bfpr_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (accept),
      .pin_i   (pin_levels_i[g]),
      .cfg_i   (cfg),
      .flags_o (flags[g])
    );
  end

  bfpr_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .accept_o    (accept),
    .flags_i     (flags),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .press_o     (press_events_o),
    .rel_o       (release_events_o),
    .rpt_o       (repeat_events_o),
    .held_o      (held_mask_o)
  );

endmodule

### sv/bfpr_checker.sv
// Port-level checks of the button filter, bound to the top level.
// Depends on bfpr_pkg and the macros in button_filter_press_repeat_macros.svh.
`include "button_filter_press_repeat_macros.svh"

module bfpr_checker import bfpr_pkg::*; #(
  parameter int unsigned BUTTONS = 4
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [BUTTONS-1:0] press_events_o,
  input logic [BUTTONS-1:0] release_events_o,
  input logic [BUTTONS-1:0] repeat_events_o,
  input logic [BUTTONS-1:0] held_mask_o
);

  // A stalled result stays offered
  `BFPR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  // A button cannot be pressed and released in the same tick
  `BFPR_ASSERT_IMP(a_press_rel, clk_i, rst_ni, out_valid_o, (press_events_o & release_events_o) == '0, "press and release together")
  // A press leaves the button held, a release leaves it free
  `BFPR_ASSERT_IMP(a_held_mask, clk_i, rst_ni, out_valid_o, ((press_events_o & ~held_mask_o) == '0) && ((release_events_o & held_mask_o) == '0), "held mask disagrees with events")
  // Repeats come only from held buttons
  `BFPR_ASSERT_IMP(a_rpt_held, clk_i, rst_ni, out_valid_o, (repeat_events_o & ~held_mask_o) == '0, "repeat from a button not held")

endmodule

bind button_filter_press_repeat bfpr_checker #(
  .BUTTONS (BUTTONS)
) u_bfpr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .press_events_o   (press_events_o),
  .release_events_o (release_events_o),
  .repeat_events_o  (repeat_events_o),
  .held_mask_o      (held_mask_o)
);
